FILE: src/utf8_scanner_whitespace_limit_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 scanner assertion macros
// Shared concurrent assertion wrappers for the scanner modules.
// ----------------------------------------------------------------------------
`ifndef UTF8_SCANNER_WHITESPACE_LIMIT_ASSERT_SVH
`define UTF8_SCANNER_WHITESPACE_LIMIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Plain property, checked outside reset.
`define U8WS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("u8ws assertion failed");
// Implication from a trigger to a consequence in the next cycle.
`define U8WS_ASSERT_NEXT(lbl, clk, rstn, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) \
        else $error("u8ws assertion failed");
`else
`define U8WS_ASSERT(lbl, clk, rstn, prop)
`define U8WS_ASSERT_NEXT(lbl, clk, rstn, trig, cons)
`endif

`endif

FILE: src/u8ws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8ws_pkg
// Types, constants and helper functions of the UTF-8 scanner.
// ----------------------------------------------------------------------------
package u8ws_pkg;

    localparam int COUNT_BITS_DEFAULT = 24;
    localparam logic [15:0] MAX_CHARS_RESET = 16'd2000;
    localparam int CP_BITS = 21;
    localparam int WIDTH_BITS = 3;
    localparam logic [31:0] PREFIX_FIELD_MAX = 32'h00FF_FFFF;

    localparam logic [2:0] WIDTH_ONE = 3'd1;
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    // One decoded character on its way to the counter stage.
    typedef struct packed {
        logic [CP_BITS-1:0]    cp;
        logic [WIDTH_BITS-1:0] width;
        logic                  last;
    } t_char;

    function automatic t_char raw_char(input logic [7:0] b);
        t_char c;
        c.cp = CP_BITS'(b);
        c.width = WIDTH_ONE;
        c.last = 1'b0;
        return c;
    endfunction

    // Expected sequence length of a lead byte; zero for ASCII and invalid leads.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_NONE;
        if ((b & 8'hE0) == 8'hC0) begin
            len = LEN_TWO;
        end else if ((b & 8'hF0) == 8'hE0) begin
            len = LEN_THREE;
        end else if ((b & 8'hF8) == 8'hF0) begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    function automatic logic is_space(input logic [CP_BITS-1:0] cp);
        return cp inside {[21'h09:21'h0D], 21'h20, 21'h85, 21'hA0, 21'h1680,
                          [21'h2000:21'h200A], 21'h2028, 21'h2029, 21'h202F,
                          21'h205F, 21'h3000};
    endfunction

endpackage

FILE: src/u8ws_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8ws_decode
// Byte-level UTF-8 sequence tracker and a four-entry character queue.
// ----------------------------------------------------------------------------
`include "utf8_scanner_whitespace_limit_assert.svh"

module u8ws_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_text,
    output logic             o_char_valid,
    output u8ws_pkg::t_char  o_char,
    input  logic             i_char_take
);

    logic [2:0][7:0] r_pend, n_pend;
    logic [1:0]      r_pcnt, n_pcnt;
    logic [2:0]      r_slen, n_slen;
    u8ws_pkg::t_char r_q [4];
    logic [2:0]      r_qn;

    u8ws_pkg::t_char list [4];
    logic [2:0]      k;
    logic [2:0]      lead_len;
    logic [20:0]     cp_full;
    logic            accept;

    assign accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_qn == 3'd0) || ((r_qn == 3'd1) && i_char_take);
    assign o_char_valid = (r_qn != 3'd0);
    assign o_char = r_q[0];

    always_comb begin
        case (r_slen)
            u8ws_pkg::LEN_TWO: begin
                cp_full = {10'd0, r_pend[0][4:0], i_text_byte[5:0]};
            end
            u8ws_pkg::LEN_THREE: begin
                cp_full = {5'd0, r_pend[0][3:0], r_pend[1][5:0], i_text_byte[5:0]};
            end
            default: begin
                cp_full = {r_pend[0][2:0], r_pend[1][5:0], r_pend[2][5:0],
                           i_text_byte[5:0]};
            end
        endcase
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            list[j] = '0;
        end
        k = 3'd0;
        n_pend = r_pend;
        n_pcnt = r_pcnt;
        n_slen = r_slen;
        lead_len = u8ws_pkg::lead_length(i_text_byte);

        if ((r_pcnt == 2'd0) || (r_slen < u8ws_pkg::LEN_TWO) ||
            (r_slen > u8ws_pkg::LEN_FOUR)) begin
            if (lead_len == u8ws_pkg::LEN_NONE) begin
                list[0] = u8ws_pkg::raw_char(i_text_byte);
                k = 3'd1;
                n_pcnt = 2'd0;
                n_slen = u8ws_pkg::LEN_NONE;
            end else begin
                n_pend[0] = i_text_byte;
                n_pcnt = 2'd1;
                n_slen = lead_len;
            end
        end else if (i_text_byte[7:6] == 2'b10) begin
            if (({1'b0, r_pcnt} + 3'd1) == r_slen) begin
                list[0].cp = cp_full;
                list[0].width = r_slen;
                list[0].last = 1'b0;
                k = 3'd1;
                n_pcnt = 2'd0;
                n_slen = u8ws_pkg::LEN_NONE;
            end else begin
                n_pend[r_pcnt] = i_text_byte;
                n_pcnt = r_pcnt + 2'd1;
            end
        end else begin
            // Broken sequence: held bytes go out raw, then the byte starts over.
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < r_pcnt) begin
                    list[i] = u8ws_pkg::raw_char(r_pend[i]);
                end
            end
            k = {1'b0, r_pcnt};
            if (lead_len == u8ws_pkg::LEN_NONE) begin
                list[k[1:0]] = u8ws_pkg::raw_char(i_text_byte);
                k = k + 3'd1;
                n_pcnt = 2'd0;
                n_slen = u8ws_pkg::LEN_NONE;
            end else begin
                n_pend[0] = i_text_byte;
                n_pcnt = 2'd1;
                n_slen = lead_len;
            end
        end

        if (i_end_of_text) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_pcnt) begin
                    list[k[1:0]] = u8ws_pkg::raw_char(n_pend[i]);
                    k = k + 3'd1;
                end
            end
            if (k != 3'd0) begin
                list[2'(k - 3'd1)].last = 1'b1;
            end
            n_pend = '0;
            n_pcnt = 2'd0;
            n_slen = u8ws_pkg::LEN_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_pcnt <= 2'd0;
            r_slen <= u8ws_pkg::LEN_NONE;
            r_qn <= 3'd0;
        end else if (accept) begin
            r_pend <= n_pend;
            r_pcnt <= n_pcnt;
            r_slen <= n_slen;
            r_qn <= k;
        end else if (i_char_take && (r_qn != 3'd0)) begin
            r_qn <= r_qn - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int j = 0; j < 4; j++) begin
                r_q[j] <= list[j];
            end
        end else if (i_char_take) begin
            for (int j = 0; j < 3; j++) begin
                r_q[j] <= r_q[j + 1];
            end
        end
    end

    `U8WS_ASSERT(a_pend_len_ok, i_clk, i_rst_n,
        (r_pcnt == 2'd0) || (({1'b0, r_pcnt} < r_slen) && (r_slen <= u8ws_pkg::LEN_FOUR)))
    `U8WS_ASSERT_NEXT(a_eot_clears, i_clk, i_rst_n,
        accept && i_end_of_text, (r_pcnt == 2'd0) && (r_qn != 3'd0))
    `U8WS_ASSERT(a_queue_depth, i_clk, i_rst_n, r_qn <= 3'd4)

endmodule

FILE: src/u8ws_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8ws_emit
// Per-character counters, whitespace flag and the result register.
// ----------------------------------------------------------------------------
`include "utf8_scanner_whitespace_limit_assert.svh"

module u8ws_emit #(
    parameter int COUNT_BITS = u8ws_pkg::COUNT_BITS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_max_chars,
    input  logic             i_char_valid,
    input  u8ws_pkg::t_char  i_char,
    output logic             o_char_take,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [20:0]      o_codepoint,
    output logic [2:0]       o_char_width,
    output logic             o_is_whitespace,
    output logic             o_within_limit,
    output logic [23:0]      o_prefix_bytes,
    output logic             o_has_content,
    output logic             o_last_char
);

    localparam int SUM_BITS = COUNT_BITS + 1;

    logic [COUNT_BITS-1:0] r_char_count, n_char_count;
    logic [COUNT_BITS-1:0] r_prefix, n_prefix;
    logic                  r_seen, n_seen;
    logic                  r_out_valid;
    logic [20:0]           r_cp;
    logic [2:0]            r_width;
    logic                  r_ws, r_within, r_has, r_last;
    logic [23:0]           r_pb, n_pb;

    logic                  ws, in_limit;
    logic [SUM_BITS-1:0]   sum;
    logic [31:0]           prefix_wide;

    assign o_char_take = i_char_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        ws = u8ws_pkg::is_space(i_char.cp);
        in_limit = 32'(r_char_count) < 32'(i_max_chars);
        sum = {1'b0, r_prefix} + SUM_BITS'(i_char.width);
        n_prefix = r_prefix;
        if (in_limit) begin
            n_prefix = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
        end
        n_char_count = (r_char_count == '1) ? r_char_count : r_char_count + 1'b1;
        n_seen = r_seen || !ws;
        prefix_wide = 32'(n_prefix);
        n_pb = (prefix_wide > u8ws_pkg::PREFIX_FIELD_MAX) ? 24'hFF_FFFF : prefix_wide[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= '0;
            r_prefix <= '0;
            r_seen <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_char_take) begin
                r_out_valid <= 1'b1;
                // The final character of a text starts the next text from zero.
                if (i_char.last) begin
                    r_char_count <= '0;
                    r_prefix <= '0;
                    r_seen <= 1'b0;
                end else begin
                    r_char_count <= n_char_count;
                    r_prefix <= n_prefix;
                    r_seen <= n_seen;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_char_take) begin
            r_cp <= i_char.cp;
            r_width <= i_char.width;
            r_ws <= ws;
            r_within <= in_limit;
            r_pb <= n_pb;
            r_has <= n_seen;
            r_last <= i_char.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_codepoint = r_cp;
    assign o_char_width = r_width;
    assign o_is_whitespace = r_ws;
    assign o_within_limit = r_within;
    assign o_prefix_bytes = r_pb;
    assign o_has_content = r_has;
    assign o_last_char = r_last;

    `U8WS_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n,
        o_char_take && i_char.last, (r_char_count == '0) && (r_prefix == '0) && !r_seen)
    `U8WS_ASSERT(a_width_range, i_clk, i_rst_n,
        !r_out_valid || ((r_width >= 3'd1) && (r_width <= 3'd4)))
    `U8WS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        r_out_valid && !i_out_ready, r_out_valid && $stable(r_cp) && $stable(r_last))

endmodule

FILE: src/utf8_scanner_whitespace_limit.sv
`timescale 1ns / 1ps
// A byte accepted is held in the decoder queue, then registered in the result register.
// Throughput: one byte per cycle while each byte yields at most one character and
// the output is not stalled; a byte that yields several characters (a broken sequence
// flushed raw) holds the input while the counter stage drains them one per cycle.
// Reset: synchronous, active low; clears held bytes and counters, limit = 2000.
// ----------------------------------------------------------------------------
// utf8_scanner_whitespace_limit
// Lenient UTF-8 decoder with whitespace flags and a character-limit prefix count.
// ----------------------------------------------------------------------------
module utf8_scanner_whitespace_limit #(
    parameter int COUNT_BITS = u8ws_pkg::COUNT_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_max_chars,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [20:0] o_codepoint,
    output logic [2:0]  o_char_width,
    output logic        o_is_whitespace,
    output logic        o_within_limit,
    output logic [23:0] o_prefix_bytes,
    output logic        o_has_content,
    output logic        o_last_char
);

    logic [15:0]     r_max_chars;
    logic            char_valid;
    logic            char_take;
    u8ws_pkg::t_char char_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= u8ws_pkg::MAX_CHARS_RESET;
        end else if (i_cfg_valid) begin
            r_max_chars <= i_cfg_max_chars;
        end
    end

    u8ws_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_char_valid  (char_valid),
        .o_char        (char_item),
        .i_char_take   (char_take)
    );

    u8ws_emit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_max_chars     (r_max_chars),
        .i_char_valid    (char_valid),
        .i_char          (char_item),
        .o_char_take     (char_take),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_codepoint     (o_codepoint),
        .o_char_width    (o_char_width),
        .o_is_whitespace (o_is_whitespace),
        .o_within_limit  (o_within_limit),
        .o_prefix_bytes  (o_prefix_bytes),
        .o_has_content   (o_has_content),
        .o_last_char     (o_last_char)
    );

endmodule
